FILE: sv/blist_pkg.sv
// Shared types and constants for the bounded list block.
package blist_pkg;

    localparam int DEPTH       = 16;
    localparam int KEY_W       = 32;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int OUT_CNT_W   = 5;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FOUND     = 3'd4,
        ST_ENTRY     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DECIDE,
        B_SCAN,
        B_SHIFT,
        B_FIN,
        B_DUMP
    } bstate_t;

    typedef struct packed {
        op_t                     op;
        logic signed [KEY_W-1:0] key;
    } cmd_t;

endpackage

FILE: sv/blist_ifs.sv
// Request and result channel interfaces for the bounded list block.
interface blist_req_if import blist_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [KEY_W-1:0] key_value;

    modport source (output valid, output req_type, output key_value, input ready);
    modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface blist_rsp_if import blist_pkg::*;;
    logic                    valid;
    logic                    ready;
    status_t                 status;
    logic signed [KEY_W-1:0] entry_value;
    logic [OUT_CNT_W-1:0]    entry_count;
    logic                    last;

    modport source (output valid, output status, output entry_value, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input status, input entry_value, input entry_count,
                    input last, output ready);
endinterface

FILE: sv/blist_front.sv
// Front end: takes requests, decodes them into commands and holds one for the queue.
module blist_front import blist_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    blist_req_if.sink  req,
    output logic       push_valid,
    input  logic       push_ready,
    output cmd_t       push_cmd
);

    logic front_valid_reg;
    logic front_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    assign req.ready  = !front_valid_reg || push_ready;
    assign take       = req.valid && req.ready;
    assign push_valid = front_valid_reg;
    assign push_cmd   = cmd_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (take)
        begin
            front_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cmd_next.key = req.key_value;
        unique case (req.req_type)
            OP_APPEND: cmd_next.op = OP_APPEND;
            OP_REMOVE: cmd_next.op = OP_REMOVE;
            OP_CHECK:  cmd_next.op = OP_CHECK;
            default:   cmd_next.op = OP_DUMP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

FILE: sv/blist_queue.sv
// Short command queue between the front end and the list engine.
module blist_queue import blist_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QP_W-1:0] rd_ptr_next;
    logic [QC_W-1:0] fill_reg;
    logic [QC_W-1:0] fill_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (fill_reg != QC_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers wrap naturally: the depth is a power of two.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QP_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QP_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + QC_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/blist_back.sv
// List engine: entry memory, count, scan/shift/dump sequencer and result register.
module blist_back import blist_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  cmd_t       pop_cmd,
    blist_rsp_if.source rsp
);

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rd_data_reg;

    bstate_t                 state_reg;
    bstate_t                 state_next;
    op_t                     op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    logic                    rsp_valid_reg;
    status_t                 rsp_status_reg;
    logic signed [KEY_W-1:0] rsp_value_reg;
    logic [OUT_CNT_W-1:0]    rsp_count_reg;
    logic                    rsp_last_reg;

    logic                    rsp_free;
    logic                    is_full;
    logic                    is_empty;
    logic                    hit;
    logic [CNT_W-1:0]        idx_p1;
    logic [CNT_W-1:0]        idx_p2;

    logic                    emit;
    status_t                 emit_status;
    logic signed [KEY_W-1:0] emit_value;
    logic                    emit_last;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [KEY_W-1:0] wdata;
    logic [IDX_W-1:0]        rd_addr;

    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign hit       = (rd_data_reg == key_reg);
    assign idx_p1    = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_p2    = CNT_W'(idx_reg) + CNT_W'(2);
    assign pop_ready = (state_reg == B_IDLE);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_value = rsp_value_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.last        = rsp_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = B_DECIDE;
                end
            end
            B_DECIDE:
            begin
                unique case (op_reg)
                    OP_APPEND:
                    begin
                        if (rsp_free)
                        begin
                            state_next = B_IDLE;
                        end
                    end
                    OP_REMOVE, OP_CHECK:
                    begin
                        if (!is_empty)
                        begin
                            state_next = B_SCAN;
                        end
                        else if (rsp_free)
                        begin
                            state_next = B_IDLE;
                        end
                    end
                    default:
                    begin
                        if (!is_empty)
                        begin
                            state_next = B_DUMP;
                        end
                        else if (rsp_free)
                        begin
                            state_next = B_IDLE;
                        end
                    end
                endcase
            end
            B_SCAN:
            begin
                priority if (hit && op_reg == OP_REMOVE)
                begin
                    state_next = (idx_p1 < count_reg) ? B_SHIFT : B_FIN;
                end
                else if (hit || idx_p1 == count_reg)
                begin
                    if (rsp_free)
                    begin
                        state_next = B_IDLE;
                    end
                end
                else
                begin
                    state_next = B_SCAN;
                end
            end
            B_SHIFT:
            begin
                if (idx_p2 >= count_reg)
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                if (rsp_free)
                begin
                    state_next = B_IDLE;
                end
            end
            B_DUMP:
            begin
                if (rsp_free && idx_p1 == count_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath controls and result
    always_comb
    begin
        emit        = 1'b0;
        emit_status = ST_DONE;
        emit_value  = key_reg;
        emit_last   = 1'b1;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = rd_data_reg;
        rd_addr     = idx_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        unique case (state_reg)
            B_IDLE:
            begin
            end
            B_DECIDE:
            begin
                unique case (op_reg)
                    OP_APPEND:
                    begin
                        if (rsp_free)
                        begin
                            emit = 1'b1;
                            if (is_full)
                            begin
                                emit_status = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = IDX_W'(count_reg);
                                wdata      = key_reg;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    OP_REMOVE, OP_CHECK:
                    begin
                        if (is_empty)
                        begin
                            emit        = rsp_free;
                            emit_status = ST_EMPTY;
                        end
                        else
                        begin
                            idx_next = '0;
                            rd_addr  = '0;
                        end
                    end
                    default:
                    begin
                        if (is_empty)
                        begin
                            emit        = rsp_free;
                            emit_status = ST_EMPTY;
                            emit_value  = '0;
                        end
                        else
                        begin
                            idx_next = '0;
                            rd_addr  = '0;
                        end
                    end
                endcase
            end
            B_SCAN:
            begin
                priority if (hit && op_reg == OP_REMOVE)
                begin
                    // prefetch the entry that moves into the hole
                    if (idx_p1 < count_reg)
                    begin
                        rd_addr = IDX_W'(idx_p1);
                    end
                end
                else if (hit)
                begin
                    emit        = rsp_free;
                    emit_status = ST_FOUND;
                end
                else if (idx_p1 == count_reg)
                begin
                    emit        = rsp_free;
                    emit_status = ST_NOT_FOUND;
                end
                else
                begin
                    idx_next = IDX_W'(idx_p1);
                    rd_addr  = IDX_W'(idx_p1);
                end
            end
            B_SHIFT:
            begin
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = rd_data_reg;
                idx_next = IDX_W'(idx_p1);
                if (idx_p2 < count_reg)
                begin
                    rd_addr = IDX_W'(idx_p2);
                end
            end
            B_FIN:
            begin
                if (rsp_free)
                begin
                    emit       = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            B_DUMP:
            begin
                emit_status = ST_ENTRY;
                emit_value  = rd_data_reg;
                emit_last   = (idx_p1 == count_reg);
                if (rsp_free)
                begin
                    emit = 1'b1;
                    if (idx_p1 != count_reg)
                    begin
                        idx_next = IDX_W'(idx_p1);
                        rd_addr  = IDX_W'(idx_p1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (pop_valid && pop_ready)
        begin
            op_reg  <= pop_cmd.op;
            key_reg <= pop_cmd.key;
        end
        if (emit)
        begin
            rsp_status_reg <= emit_status;
            rsp_value_reg  <= emit_value;
            rsp_count_reg  <= OUT_CNT_W'(count_next);
            rsp_last_reg   <= emit_last;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> rsp_free)
        else $error("result register overwritten while still pending");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DECIDE && op_reg == OP_APPEND && rsp_free && !is_full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow the count");

    a_shift_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_SHIFT |-> idx_p1 < count_reg)
        else $error("shift reads past the end of the list");

    a_dump_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DUMP |-> CNT_W'(idx_reg) < count_reg)
        else $error("dump index past the end of the list");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> state_reg == B_DECIDE)
        else $error("popped command not decided");

endmodule

FILE: sv/bounded_list_add_remove_search_core.sv
// A request passes the front register and the command queue; the engine takes it while idle,
// decides it and writes the result register. Check scans entries in turn, remove then moves
// the later entries down one by one; a dump gives its first entry after the decide state, then
// one a cycle while the result side is ready. The engine sequences one request at a time.
// The front register and a 2-entry command queue let requests arrive while the engine works.
// Reset: asynchronous, active low; clears the count and all handshake state, entries are
// left as they are and are never read before being written.
module bounded_list_add_remove_search_core import blist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    blist_req_if.sink   req,
    blist_rsp_if.source rsp
);

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    blist_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    blist_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    blist_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rsp       (rsp)
    );

endmodule

FILE: bench/bounded_list_add_remove_search_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the bounded list core: directed corners, fill/drain, random mixes and back-pressure.
module bounded_list_add_remove_search_core_tb;
    import blist_pkg::*;

    typedef struct {
        status_t                 status;
        logic signed [KEY_W-1:0] value;
        logic [OUT_CNT_W-1:0]    count;
        logic                    last;
    } list_result_t;

    logic clk;
    logic rst_n;

    blist_req_if req_ch ();
    blist_rsp_if rsp_ch ();

    bounded_list_add_remove_search_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the list, updated when a request is accepted
    logic signed [KEY_W-1:0] shadow_vals [DEPTH];
    int                      shadow_len;
    list_result_t            pending_results [$];

    int idle_pct;
    int stall_pct;
    int hold_left;
    int requests_sent;
    int results_checked;
    int dumps_sent;
    int full_hits;
    int mismatch_count;

    logic signed [KEY_W-1:0] corner_keys [8] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
        32'sh0000_0001, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_8000
    };

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic void queue_result(status_t st, logic signed [KEY_W-1:0] val,
                                         logic last_mark);
        list_result_t r;
        r.status = st;
        r.value  = val;
        r.count  = OUT_CNT_W'(shadow_len);
        r.last   = last_mark;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_list_op(op_t op, logic signed [KEY_W-1:0] key);
        int pos;
        pos = -1;
        case (op)
            OP_APPEND:
            begin
                if (shadow_len >= DEPTH)
                begin
                    full_hits++;
                    queue_result(ST_FULL, key, 1'b1);
                end
                else
                begin
                    shadow_vals[shadow_len] = key;
                    shadow_len++;
                    queue_result(ST_DONE, key, 1'b1);
                end
            end
            OP_REMOVE, OP_CHECK:
            begin
                if (shadow_len == 0)
                begin
                    queue_result(ST_EMPTY, key, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < shadow_len; i++)
                    begin
                        if (pos < 0 && shadow_vals[i] === key)
                            pos = i;
                    end
                    if (pos < 0)
                        queue_result(ST_NOT_FOUND, key, 1'b1);
                    else if (op == OP_CHECK)
                        queue_result(ST_FOUND, key, 1'b1);
                    else
                    begin
                        // close the gap, touching only live entries
                        for (int i = pos; i + 1 < shadow_len; i++)
                            shadow_vals[i] = shadow_vals[i + 1];
                        shadow_len--;
                        queue_result(ST_DONE, key, 1'b1);
                    end
                end
            end
            default:
            begin
                if (shadow_len == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < shadow_len; i++)
                        queue_result(ST_ENTRY, shadow_vals[i], i == shadow_len - 1);
            end
        endcase
    endfunction

    task automatic send_request(input op_t op, input logic signed [KEY_W-1:0] key);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.key_value <= key;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_list_op(op, key);
        requests_sent++;
        if (op == OP_DUMP)
            dumps_sent++;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (shadow_len > 0 && r < 55)
            return shadow_vals[$urandom_range(shadow_len - 1)];
        else if (r < 75)
            return corner_keys[$urandom_range(7)];
        else
            return $urandom;
    endfunction

    function automatic op_t pick_op();
        int r;
        int append_w;
        append_w = (shadow_len > 10) ? 25 : 45;
        r = $urandom_range(99);
        if (r < append_w)
            return OP_APPEND;
        else if (r < append_w + 25)
            return OP_REMOVE;
        else if (r < append_w + 45)
            return OP_CHECK;
        else
            return OP_DUMP;
    endfunction

    // Receive side: random stall, long hold-off on request, and the result check
    initial
    begin
        list_result_t want;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result status %0d value %0d",
                                              rsp_ch.status, rsp_ch.entry_value));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.entry_value !== want.value)
                        report_mismatch($sformatf("entry_value %0d, want %0d",
                                                  rsp_ch.entry_value, want.value));
                    if (rsp_ch.entry_count !== want.count)
                        report_mismatch($sformatf("entry_count %0d, want %0d",
                                                  rsp_ch.entry_count, want.count));
                    if (rsp_ch.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  rsp_ch.last, want.last));
                    results_checked++;
                end
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic test_corner_cases();
        send_request(OP_DUMP,   32'sh1234_5678);
        send_request(OP_REMOVE, 32'sh8000_0000);
        send_request(OP_CHECK,  32'sh7FFF_FFFF);
        send_request(OP_APPEND, 32'sh7FFF_FFFF);
        send_request(OP_APPEND, 32'sh8000_0000);
        send_request(OP_APPEND, 32'sh0000_0000);
        send_request(OP_APPEND, 32'sh7FFF_FFFF);
        send_request(OP_CHECK,  32'sh8000_0000);
        send_request(OP_CHECK,  32'sh0000_0001);
        // duplicate key: only the first copy goes
        send_request(OP_REMOVE, 32'sh7FFF_FFFF);
        send_request(OP_DUMP,   32'sh0);
        send_request(OP_REMOVE, 32'sh7FFF_FFFF);
        send_request(OP_REMOVE, 32'shFFFF_FFFF);
        send_request(OP_REMOVE, 32'sh8000_0000);
        send_request(OP_DUMP,   32'shFFFF_FFFF);
    endtask

    task automatic test_fill_and_drain();
        while (shadow_len < DEPTH)
            send_request(OP_APPEND, $urandom);
        send_request(OP_APPEND, 32'sh8000_0000);
        send_request(OP_APPEND, 32'sh7FFF_FFFF);
        send_request(OP_DUMP, $urandom);
        while (shadow_len > 0)
            send_request(OP_REMOVE, shadow_vals[$urandom_range(shadow_len - 1)]);
        send_request(OP_DUMP, $urandom);
    endtask

    task automatic test_random_mix(input int n);
        op_t op;
        for (int i = 0; i < n; i++)
        begin
            op = pick_op();
            send_request(op, pick_key());
        end
    endtask

    // Hold the result side off so the internal queue fills and stalls the request side
    task automatic test_backpressure();
        hold_left = 300;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 4 == 3)
                send_request(OP_DUMP, $urandom);
            else
                send_request(OP_APPEND, pick_key());
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_results.size() > 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_results.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= OP_APPEND;
        req_ch.key_value <= '0;
        shadow_len      = 0;
        idle_pct        = 0;
        stall_pct       = 0;
        requests_sent   = 0;
        results_checked = 0;
        dumps_sent      = 0;
        full_hits       = 0;
        mismatch_count  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_fill_and_drain();
        idle_pct  = 88;
        stall_pct = 0;
        test_random_mix(60);
        idle_pct  = 0;
        stall_pct = 88;
        test_random_mix(60);
        idle_pct  = 32;
        stall_pct = 32;
        test_random_mix(60);
        test_fill_and_drain();
        idle_pct  = 0;
        stall_pct = 0;
        test_backpressure();
        test_random_mix(60);

        req_ch.valid <= 1'b0;
        wait_drained();

        $display("Sent %0d requests (%0d dumps, %0d appends on a full list), compared %0d results.",
                 requests_sent, dumps_sent, full_hits, results_checked);
        $display("Phases: no idling, sparse requests, heavy result stall, mixed, long hold-off.");
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
